// ===== hw/rtl/sobel_edge_magnitude_macros.svh =====
// Assertion macros shared by the Sobel edge magnitude RTL.
`ifndef SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SEM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sem_pkg.sv =====
// Types and constants for the Sobel edge magnitude block.
package sem_pkg;

    localparam int PIX_W       = 8;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int ROW_W       = 11;
    localparam int MAX_ROWS    = 1024;
    localparam int GRAD_W      = 10;
    localparam int SUM_W       = 21;
    localparam int ROOT_W      = 8;
    localparam int ROOT_STEP_W = 3;

    localparam logic [CFG_W-1:0] MIN_DIM      = 11'd3;
    localparam logic [CFG_W-1:0] MAX_HEIGHT   = CFG_W'(MAX_ROWS);
    localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [ROOT_W-1:0] SAT_VALUE = 8'd255;
    localparam logic [SUM_W-1:0]  SQ_LIMIT  = 21'd65536;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] pixel;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             frame_last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_GRAD,
        S_SQX,
        S_SQY,
        S_ROOT,
        S_OUT
    } t_state;

endpackage

// ===== hw/rtl/sem_root.sv =====
// Bit-serial integer square root, one result bit per cycle, saturated to 255.
module sem_root
    import sem_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_sum,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic                   r_busy;
    logic                   r_done;
    logic [ROOT_STEP_W-1:0] r_bit;
    logic [SUM_W-1:0]       r_sum;
    logic [ROOT_W-1:0]      r_root;

    logic [ROOT_W-1:0]   trial;
    logic [2*ROOT_W-1:0] trial_sq;

    assign trial    = r_root | (ROOT_W'(1) << r_bit);
    assign trial_sq = trial * trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_bit  <= ROOT_STEP_W'(ROOT_W - 1);
            end else if (r_busy) begin
                r_bit <= r_bit - ROOT_STEP_W'(1);
                if (r_bit == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum  <= i_sum;
            r_root <= '0;
        end else if (r_busy && (SUM_W'(trial_sq) <= r_sum)) begin
            r_root <= trial;
        end
    end

    assign o_done = r_done;
    assign o_root = (r_sum >= SQ_LIMIT) ? SAT_VALUE : r_root;

endmodule

// ===== hw/rtl/sobel_edge_magnitude.sv =====
// Sobel 3x3 edge magnitude over a raster pixel stream: line memory, window and control.
//
// Pixels enter in raster order; each result is the pixel image_width+1 positions
// back, as floor(sqrt(gx^2+gy^2)) saturated to 255, or the pixel itself on the frame
// border. Items are handled one at a time: an item that yields no result goes back to
// S_IDLE after S_READ, a border result goes from S_GRAD to S_OUT, and an interior
// result runs S_SQX, S_SQY and the 8-step bit-serial root in S_ROOT; S_OUT holds each
// result until the output register is free. Both line stores share one line memory,
// read once per item and written back unless the item is ignored. The line memory is
// not cleared after reset. A configuration write restarts the frame; after the last
// pixel the host sends image_width+1 drain items to flush the remaining results.
`include "sobel_edge_magnitude_macros.svh"

module sobel_edge_magnitude
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int WEW = $clog2(MAX_WIDTH + 1);
    localparam int CLW = $clog2(MAX_WIDTH);
    localparam int XW  = (WEW > CFG_W) ? WEW : CFG_W;
    localparam int PW  = $clog2(MAX_WIDTH * MAX_ROWS) + 1;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_cfg_width;
    logic [CFG_W-1:0] r_cfg_height;
    logic [PW-1:0]    r_frame_len;

    logic [CLW-1:0]   r_in_col;
    logic [ROW_W-1:0] r_in_row;
    logic [PW-1:0]    r_in_pos;
    logic [PW-1:0]    r_out_pos;
    logic [PIX_W-1:0] r_win [9];

    logic [2*PIX_W-1:0] r_line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_line_rd;

    logic             r_action;
    logic [PIX_W-1:0] r_pixel;
    logic             r_border;
    logic             r_last;
    logic [GRAD_W-1:0] r_ax;
    logic [GRAD_W-1:0] r_ay;
    logic [2*GRAD_W-1:0] r_sq;

    logic      r_out_valid;
    t_out_item r_out_data;

    // control from the state machine
    logic in_ready, mem_rd, step, grad_load, sqx_load, root_start, out_load;

    logic [XW-1:0]    cfg_width_x;
    logic [WEW-1:0]   w_eff;
    logic [CFG_W-1:0] h_eff;
    logic             cfg_we;
    logic             in_frame;
    logic             ignore;
    logic             has_out;
    logic             is_last;
    logic             out_free;
    logic [WEW-1:0]   col_inc;
    logic [PIX_W-1:0] new_px;
    logic [PIX_W-1:0] rd_older, rd_newer;
    logic [PIX_W-1:0] n_win [9];

    logic [GRAD_W-1:0]   gx_pos, gx_neg, gy_pos, gy_neg;
    logic [2*GRAD_W-1:0] ax_sq, ay_sq;
    logic [SUM_W-1:0]    root_sum;
    logic                root_done;
    logic [ROOT_W-1:0]   root_value;

    // effective frame size
    assign cfg_width_x = XW'(r_cfg_width);

    always_comb begin
        priority if (r_cfg_width < MIN_DIM) begin
            w_eff = WEW'(MIN_DIM);
        end else if (cfg_width_x > XW'(MAX_WIDTH)) begin
            w_eff = WEW'(MAX_WIDTH);
        end else begin
            w_eff = WEW'(cfg_width_x);
        end
    end

    always_comb begin
        priority if (r_cfg_height < MIN_DIM) begin
            h_eff = MIN_DIM;
        end else if (r_cfg_height > MAX_HEIGHT) begin
            h_eff = MAX_HEIGHT;
        end else begin
            h_eff = r_cfg_height;
        end
    end

    assign cfg_we   = i_cfg_valid &&
                      ((i_cfg_index == CFG_IMAGE_WIDTH) || (i_cfg_index == CFG_IMAGE_HEIGHT));
    assign in_frame = r_in_pos < r_frame_len;
    assign ignore   = in_frame && r_action;
    assign has_out  = r_in_pos >= (PW'(w_eff) + PW'(1));
    assign is_last  = r_out_pos == (r_frame_len - PW'(1));
    assign out_free = !r_out_valid || i_out_ready;
    assign col_inc  = WEW'(r_in_col) + WEW'(1);
    assign new_px   = in_frame ? r_pixel : '0;
    assign rd_older = r_line_rd[2*PIX_W-1:PIX_W];
    assign rd_newer = r_line_rd[PIX_W-1:0];

    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = rd_older;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = rd_newer;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = new_px;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_READ;
            S_READ:  n_state = (ignore || !has_out) ? S_IDLE : S_GRAD;
            S_GRAD:  n_state = r_border ? S_OUT : S_SQX;
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_ROOT;
            S_ROOT:  if (root_done) n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready   = 1'b0;
        mem_rd     = 1'b0;
        step       = 1'b0;
        grad_load  = 1'b0;
        sqx_load   = 1'b0;
        root_start = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                mem_rd   = i_in_valid;
            end
            S_READ:  step       = !ignore;
            S_GRAD:  grad_load  = 1'b1;
            S_SQX:   sqx_load   = 1'b1;
            S_SQY:   root_start = 1'b1;
            S_ROOT:  ;
            S_OUT:   out_load   = out_free;
            default: ;
        endcase
    end

    // line memory: {older, newer} per column
    always_ff @(posedge i_clk) begin
        if (mem_rd) begin
            r_line_rd <= r_line_mem[r_in_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_line_mem[r_in_col] <= {rd_newer, new_px};
        end
    end

    // control state, positions, window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_width  <= RESET_WIDTH;
            r_cfg_height <= RESET_HEIGHT;
            r_frame_len  <= PW'(RESET_WIDTH) * PW'(RESET_HEIGHT);
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_in_pos     <= '0;
            r_out_pos    <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < 9; i++) r_win[i] <= '0;
        end else begin
            r_state     <= n_state;
            r_frame_len <= PW'(w_eff) * PW'(h_eff);

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_we) begin
                if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                    r_cfg_width <= i_cfg_data;
                end else begin
                    r_cfg_height <= i_cfg_data;
                end
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_in_pos  <= '0;
                r_out_pos <= '0;
                for (int i = 0; i < 9; i++) r_win[i] <= '0;
            end else if (step) begin
                r_win <= n_win;
                if (has_out && is_last) begin
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_in_pos  <= '0;
                    r_out_pos <= '0;
                end else begin
                    r_in_pos <= r_in_pos + PW'(1);
                    if (has_out) r_out_pos <= r_out_pos + PW'(1);
                    if (col_inc >= w_eff) begin
                        r_in_col <= '0;
                        r_in_row <= r_in_row + ROW_W'(1);
                    end else begin
                        r_in_col <= col_inc[CLW-1:0];
                    end
                end
            end else if (out_load && r_last) begin
                for (int i = 0; i < 9; i++) r_win[i] <= '0;
            end
        end
    end

    // gradients from the window
    assign gx_pos = GRAD_W'(r_win[2]) + (GRAD_W'(r_win[5]) << 1) + GRAD_W'(r_win[8]);
    assign gx_neg = GRAD_W'(r_win[0]) + (GRAD_W'(r_win[3]) << 1) + GRAD_W'(r_win[6]);
    assign gy_pos = GRAD_W'(r_win[6]) + (GRAD_W'(r_win[7]) << 1) + GRAD_W'(r_win[8]);
    assign gy_neg = GRAD_W'(r_win[0]) + (GRAD_W'(r_win[1]) << 1) + GRAD_W'(r_win[2]);

    assign ax_sq    = r_ax * r_ax;
    assign ay_sq    = r_ay * r_ay;
    assign root_sum = SUM_W'(r_sq) + SUM_W'(ay_sq);

    // payload registers
    always_ff @(posedge i_clk) begin
        if (mem_rd) begin
            r_action <= i_in_data.action;
            r_pixel  <= i_in_data.pixel;
        end
        if (step) begin
            r_border <= (r_in_col == '0) || (r_in_col == CLW'(1)) ||
                        (r_in_row == ROW_W'(1)) || (r_in_row == h_eff);
            r_last   <= is_last;
        end
        if (grad_load) begin
            r_ax <= (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
            r_ay <= (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
        end
        if (sqx_load) begin
            r_sq <= ax_sq;
        end
        if (out_load) begin
            r_out_data.edge_value <= r_border ? r_win[4] : root_value;
            r_out_data.frame_last <= r_last;
        end
    end

    sem_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_sum   (root_sum),
        .o_done  (root_done),
        .o_root  (root_value)
    );

    assign o_in_ready  = in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `SEM_ASSERT_NEXT(a_accept_reads, i_in_valid && o_in_ready, r_state == S_READ, "transfer did not start a read")
    `SEM_ASSERT_IMPL(a_col_range, 1'b1, WEW'(r_in_col) < w_eff, "column beyond row width")
    `SEM_ASSERT_IMPL(a_root_state, root_done, r_state == S_ROOT, "root finished outside wait state")
    `SEM_ASSERT_IMPL(a_out_source, $rose(o_out_valid), $past(r_state) == S_OUT, "result loaded outside output state")

endmodule
